// ===== rtl/boxds_pkg.sv =====
// ----------------------------------------------------------------------------
// boxds_pkg
// Shared types and constants of the box average downscaler.
// ----------------------------------------------------------------------------
package boxds_pkg;

  localparam int unsigned PixW       = 8;
  localparam int unsigned FactorRegW = 5;
  localparam int unsigned WidthRegW  = 12;
  localparam int unsigned HeightRegW = 16;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned NumChan    = 3;
  localparam int unsigned StepW      = $clog2(PixW);

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // register indexes of the configuration port
  localparam cfg_idx_t CfgScaleFactor = cfg_idx_t'(0);
  localparam cfg_idx_t CfgFrameWidth  = cfg_idx_t'(1);
  localparam cfg_idx_t CfgFrameHeight = cfg_idx_t'(2);
  localparam cfg_idx_t CfgColorMode   = cfg_idx_t'(3);

  localparam logic [FactorRegW-1:0] FactorReset = FactorRegW'(1);
  localparam logic [WidthRegW-1:0]  WidthReset  = WidthRegW'(2048);
  localparam logic [HeightRegW-1:0] HeightReset = HeightRegW'(1);

  typedef enum logic [1:0] {
    StIdle,
    StRmw,
    StDiv,
    StOut
  } state_e;

endpackage

// ===== rtl/boxds_ram.sv =====
// ----------------------------------------------------------------------------
// boxds_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module boxds_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

// ===== rtl/box_average_downscaler.sv =====
// ----------------------------------------------------------------------------
// box_average_downscaler
// Integer-factor box filter downscaler for gray or RGB raster streams.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order; each output pixel is the floor of the mean of
// an f x f block, per channel. Columns and rows past the last whole block are
// dropped. Open block sums live in a single-port line store, one entry per
// output column, updated read-modify-write. A pixel in a dropped column or
// row is only counted; a pixel inside a kept block takes a line store read,
// then a write back; the pixel that closes a block takes a read, a write
// back, an 8-step restoring divide by f*f shared by all three channels and an
// output load, which waits while the output register is still held.
// A finished result waits in the output register while new pixels are taken.
// Any write to a listed register restarts the frame position counters.
// ----------------------------------------------------------------------------
module box_average_downscaler #(
  parameter int unsigned MaxWidth  = 2048,
  parameter int unsigned MaxFactor = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [boxds_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [boxds_pkg::CfgDataW-1:0]       cfg_data_i,
  // input pixels
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [boxds_pkg::PixW-1:0]           chan_red_i,
  input  logic [boxds_pkg::PixW-1:0]           chan_green_i,
  input  logic [boxds_pkg::PixW-1:0]           chan_blue_i,
  // output pixels
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [boxds_pkg::PixW-1:0]           avg_red_o,
  output logic [boxds_pkg::PixW-1:0]           avg_green_o,
  output logic [boxds_pkg::PixW-1:0]           avg_blue_o,
  output logic                                 row_end_o,
  output logic                                 frame_end_o
);

  localparam int unsigned PixW    = boxds_pkg::PixW;
  localparam int unsigned NumChan = boxds_pkg::NumChan;
  localparam int unsigned StepW   = boxds_pkg::StepW;
  localparam int unsigned ColW    = $clog2(MaxWidth);
  localparam int unsigned WW      = ColW + 1;
  localparam int unsigned RowW    = boxds_pkg::HeightRegW;
  localparam int unsigned BW      = $clog2(MaxFactor);
  localparam int unsigned FW      = $clog2(MaxFactor + 1);
  localparam int unsigned SumW    = PixW + 2 * BW;
  localparam int unsigned AreaW   = 2 * FW;
  localparam int unsigned TW      = AreaW + PixW;
  localparam int unsigned CCmpW   = ((ColW > FW) ? ColW : FW) + 2;
  localparam int unsigned RCmpW   = ((RowW > FW) ? RowW : FW) + 2;

  // configuration registers
  logic [boxds_pkg::FactorRegW-1:0] scale_q;
  logic [boxds_pkg::WidthRegW-1:0]  width_q;
  logic [boxds_pkg::HeightRegW-1:0] height_q;
  logic                             mode_q;
  logic                             cfg_fire;
  logic                             cfg_hit;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_comb begin
    unique case (cfg_index_i)
      boxds_pkg::CfgScaleFactor,
      boxds_pkg::CfgFrameWidth,
      boxds_pkg::CfgFrameHeight,
      boxds_pkg::CfgColorMode: cfg_hit = 1'b1;
      default:                 cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= boxds_pkg::FactorReset;
      width_q  <= boxds_pkg::WidthReset;
      height_q <= boxds_pkg::HeightReset;
      mode_q   <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        boxds_pkg::CfgScaleFactor: scale_q  <= cfg_data_i[boxds_pkg::FactorRegW-1:0];
        boxds_pkg::CfgFrameWidth:  width_q  <= cfg_data_i[boxds_pkg::WidthRegW-1:0];
        boxds_pkg::CfgFrameHeight: height_q <= cfg_data_i[boxds_pkg::HeightRegW-1:0];
        boxds_pkg::CfgColorMode:   mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamped configuration
  logic [FW-1:0]   f_eff;
  logic [FW-1:0]   fm1;
  logic [WW-1:0]   w_eff;
  logic [RowW-1:0] h_eff;

  always_comb begin
    if (scale_q == '0) begin
      f_eff = FW'(1);
    end else if (32'(scale_q) > MaxFactor) begin
      f_eff = FW'(MaxFactor);
    end else begin
      f_eff = FW'(scale_q);
    end
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MaxWidth) begin
      w_eff = WW'(MaxWidth);
    end else begin
      w_eff = WW'(width_q);
    end
    h_eff = (height_q == '0) ? RowW'(1) : height_q;
  end

  assign fm1 = f_eff - FW'(1);

  // frame position counters
  logic [ColW-1:0] pix_col_q, pix_col_d;
  logic [RowW-1:0] pix_row_q, pix_row_d;
  logic [BW-1:0]   cib_q, cib_d;
  logic [BW-1:0]   rib_q, rib_d;
  logic [ColW-1:0] out_col_q, out_col_d;

  logic             in_fire;
  logic [CCmpW-1:0] blk_col;
  logic [RCmpW-1:0] blk_row;
  logic             col_fit, row_fit, active;
  logic             blk_first, blk_last, blk_rend, blk_fend;
  logic             col_end, col_wrap, row_last, row_wrap;

  // block start coordinates decide cropping and the row and frame end marks
  assign blk_col   = CCmpW'(pix_col_q) - CCmpW'(cib_q);
  assign blk_row   = RCmpW'(pix_row_q) - RCmpW'(rib_q);
  assign col_fit   = (blk_col + CCmpW'(f_eff)) <= CCmpW'(w_eff);
  assign row_fit   = (blk_row + RCmpW'(f_eff)) <= RCmpW'(h_eff);
  assign active    = col_fit & row_fit;
  assign blk_rend  = (blk_col + CCmpW'({f_eff, 1'b0})) > CCmpW'(w_eff);
  assign blk_fend  = blk_rend & ((blk_row + RCmpW'({f_eff, 1'b0})) > RCmpW'(h_eff));
  assign col_end   = FW'(cib_q) == fm1;
  assign row_last  = FW'(rib_q) == fm1;
  assign blk_first = (cib_q == '0) & (rib_q == '0);
  assign blk_last  = col_end & row_last;
  assign col_wrap  = (WW'(pix_col_q) + WW'(1)) >= w_eff;
  assign row_wrap  = ((RowW + 1)'(pix_row_q) + (RowW + 1)'(1)) >= (RowW + 1)'(h_eff);

  always_comb begin
    pix_col_d = pix_col_q;
    pix_row_d = pix_row_q;
    cib_d     = cib_q;
    rib_d     = rib_q;
    out_col_d = out_col_q;
    if (cfg_fire && cfg_hit) begin
      pix_col_d = '0;
      pix_row_d = '0;
      cib_d     = '0;
      rib_d     = '0;
      out_col_d = '0;
    end else if (in_fire) begin
      if (col_end) begin
        cib_d     = '0;
        out_col_d = out_col_q + ColW'(1);
      end else begin
        cib_d = cib_q + BW'(1);
      end
      pix_col_d = pix_col_q + ColW'(1);
      if (col_wrap) begin
        pix_col_d = '0;
        cib_d     = '0;
        out_col_d = '0;
        rib_d     = row_last ? '0 : rib_q + BW'(1);
        pix_row_d = pix_row_q + RowW'(1);
        if (row_wrap) begin
          pix_row_d = '0;
          rib_d     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_col_q <= '0;
      pix_row_q <= '0;
      cib_q     <= '0;
      rib_q     <= '0;
      out_col_q <= '0;
    end else begin
      pix_col_q <= pix_col_d;
      pix_row_q <= pix_row_d;
      cib_q     <= cib_d;
      rib_q     <= rib_d;
      out_col_q <= out_col_d;
    end
  end

  // state machine
  boxds_pkg::state_e state_q, state_d;
  logic              ram_re, ram_we, div_load, div_step, out_load;
  logic [StepW-1:0]  step_q;
  logic              out_valid_q;
  logic              blk_first_q, blk_last_q, blk_rend_q, blk_fend_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      boxds_pkg::StIdle: if (in_fire && active) state_d = boxds_pkg::StRmw;
      boxds_pkg::StRmw:  state_d = blk_last_q ? boxds_pkg::StDiv : boxds_pkg::StIdle;
      boxds_pkg::StDiv:  if (step_q == '0) state_d = boxds_pkg::StOut;
      boxds_pkg::StOut:  if (out_load) state_d = boxds_pkg::StIdle;
      default:           state_d = boxds_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    div_load   = 1'b0;
    div_step   = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      boxds_pkg::StIdle: in_ready_o = 1'b1;
      boxds_pkg::StRmw: begin
        ram_we   = 1'b1;
        div_load = blk_last_q;
      end
      boxds_pkg::StDiv:  div_step = 1'b1;
      boxds_pkg::StOut:  out_load = ~out_valid_q | out_ready_i;
      default: ;
    endcase
  end

  assign in_fire = in_valid_i & in_ready_o;
  assign ram_re  = in_fire & active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= boxds_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // pixel and block flags captured on accept of a pixel in a kept block
  logic [PixW-1:0] px_q [NumChan];
  logic [ColW-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      px_q[0]     <= chan_red_i;
      px_q[1]     <= chan_green_i;
      px_q[2]     <= chan_blue_i;
      blk_first_q <= blk_first;
      blk_last_q  <= blk_last;
      blk_rend_q  <= blk_rend;
      blk_fend_q  <= blk_fend;
      idx_q       <= out_col_q;
    end
  end

  // line store of open block sums
  logic [NumChan*SumW-1:0] ram_rdata, ram_wdata;
  logic [SumW-1:0]         new_sum [NumChan];
  logic [ColW-1:0]         ram_addr;

  assign ram_addr = ram_we ? idx_q : out_col_q;

  for (genvar c = 0; c < NumChan; c++) begin : g_sum
    assign new_sum[c] = blk_first_q ? SumW'(px_q[c])
                                    : ram_rdata[c*SumW +: SumW] + SumW'(px_q[c]);
    assign ram_wdata[c*SumW +: SumW] = new_sum[c];
  end

  boxds_ram #(
    .Width (NumChan * SumW),
    .Depth (MaxWidth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // restoring divide by f*f, one quotient bit per cycle for all channels
  logic [TW-1:0]    rem_q [NumChan];
  logic [PixW-1:0]  quo_q [NumChan];
  logic [AreaW-1:0] area_q;
  logic [TW-1:0]    trial;

  assign trial = TW'(area_q) << step_q;

  always_ff @(posedge clk_i) begin
    if (div_load) begin
      area_q <= AreaW'(f_eff) * AreaW'(f_eff);
      step_q <= StepW'(PixW - 1);
      for (int c = 0; c < NumChan; c++) begin
        rem_q[c] <= TW'(new_sum[c]);
        quo_q[c] <= '0;
      end
    end else if (div_step) begin
      step_q <= step_q - StepW'(1);
      for (int c = 0; c < NumChan; c++) begin
        if (rem_q[c] >= trial) begin
          rem_q[c] <= rem_q[c] - trial;
          quo_q[c] <= {quo_q[c][PixW-2:0], 1'b1};
        end else begin
          quo_q[c] <= {quo_q[c][PixW-2:0], 1'b0};
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      avg_red_o   <= quo_q[0];
      avg_green_o <= mode_q ? quo_q[1] : '0;
      avg_blue_o  <= mode_q ? quo_q[2] : '0;
      row_end_o   <= blk_rend_q;
      frame_end_o <= blk_fend_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
